[rtl/core/e2q_pkg.sv]
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types, fixed-point widths and the CORDIC arctangent table for the
// Euler Z-Y-X to quaternion converter.
// ----------------------------------------------------------------------------
package e2q_pkg;

	localparam int TRIG_ITERATIONS = 16;
	localparam int TBL_LEN         = 24;
	localparam int TRIG_STAGES     = (TRIG_ITERATIONS > TBL_LEN) ? TBL_LEN : TRIG_ITERATIONS;
	localparam int NUM_AXES        = 3;

	localparam int ANGLE_W = 18;
	localparam int ANG_W   = 33;    // Q.30 angle residue
	localparam int XY_W    = 34;    // Q.30 CORDIC vector
	localparam int TRIG_W  = 24;    // Q.20 cos/sin
	localparam int PROD_W  = 2 * TRIG_W;
	localparam int SUM_W   = PROD_W + 1;
	localparam int QUAT_W  = 16;

	localparam logic signed [XY_W-1:0]  CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [ANG_W-1:0] PI_Q30      = 33'sd3373259426;
	localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 33'sd1686629713;
	localparam logic signed [QUAT_W-1:0] OUT_LIMIT  = 16'sd16384;

	typedef logic signed [ANGLE_W-1:0] angle_t;
	typedef logic signed [TRIG_W-1:0]  q20_t;
	typedef logic signed [QUAT_W-1:0]  quat_t;

	typedef struct packed {
		q20_t c;
		q20_t s;
	} trig_t;

	function automatic logic signed [ANG_W-1:0] atan_entry(input int idx);
		logic [31:0] v;
		unique case (idx)
			0:  v = 32'd843314856;
			1:  v = 32'd497837829;
			2:  v = 32'd263043836;
			3:  v = 32'd133525158;
			4:  v = 32'd66908022;
			5:  v = 32'd33500507;
			6:  v = 32'd16775850;
			7:  v = 32'd8388437;
			8:  v = 32'd4194282;
			9:  v = 32'd2097149;
			10: v = 32'd1048575;
			11: v = 32'd524287;
			12: v = 32'd262143;
			13: v = 32'd131071;
			14: v = 32'd65535;
			15: v = 32'd32767;
			16: v = 32'd16383;
			17: v = 32'd8191;
			18: v = 32'd4095;
			19: v = 32'd2047;
			20: v = 32'd1023;
			21: v = 32'd511;
			22: v = 32'd255;
			default: v = 32'd127;
		endcase
		return $signed({1'b0, v});
	endfunction

endpackage

[rtl/core/e2q_trig.sv]
// ----------------------------------------------------------------------------
// e2q_trig
// Three-lane pipelined CORDIC: halves and folds each angle, one rotation step
// per stage, then rounds cosine and sine of each half angle to Q.20.
// ----------------------------------------------------------------------------
module e2q_trig (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  e2q_pkg::angle_t angle [e2q_pkg::NUM_AXES],
	output logic            out_valid,
	output e2q_pkg::trig_t  trig [e2q_pkg::NUM_AXES]
);
	import e2q_pkg::*;

	logic signed [ANG_W-1:0] t_s  [TRIG_STAGES+1][NUM_AXES];
	logic signed [XY_W-1:0]  x_s  [TRIG_STAGES+1][NUM_AXES];
	logic signed [XY_W-1:0]  y_s  [TRIG_STAGES+1][NUM_AXES];
	logic                    neg_s [TRIG_STAGES+1][NUM_AXES];
	logic                    vld_s [TRIG_STAGES+2];

	// fold the half angle into [-pi/2, pi/2]
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				logic signed [ANG_W-1:0] t;
				t = ANG_W'(angle[a]) <<< 14;
				if (t > HALF_PI_Q30) begin
					t_s[0][a]   <= PI_Q30 - t;
					neg_s[0][a] <= 1'b1;
				end else if (t < -HALF_PI_Q30) begin
					t_s[0][a]   <= -PI_Q30 - t;
					neg_s[0][a] <= 1'b1;
				end else begin
					t_s[0][a]   <= t;
					neg_s[0][a] <= 1'b0;
				end
				x_s[0][a] <= CORDIC_GAIN;
				y_s[0][a] <= '0;
			end
		end
	end

	for (genvar i = 0; i < TRIG_STAGES; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				for (int a = 0; a < NUM_AXES; a++) begin
					if (!t_s[i][a][ANG_W-1]) begin
						x_s[i+1][a] <= x_s[i][a] - (y_s[i][a] >>> i);
						y_s[i+1][a] <= y_s[i][a] + (x_s[i][a] >>> i);
						t_s[i+1][a] <= t_s[i][a] - atan_entry(i);
					end else begin
						x_s[i+1][a] <= x_s[i][a] + (y_s[i][a] >>> i);
						y_s[i+1][a] <= y_s[i][a] - (x_s[i][a] >>> i);
						t_s[i+1][a] <= t_s[i][a] + atan_entry(i);
					end
					neg_s[i+1][a] <= neg_s[i][a];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < NUM_AXES; a++) begin
				logic signed [XY_W-1:0] xc;
				logic signed [XY_W-1:0] xr;
				logic signed [XY_W-1:0] yr;
				xc = neg_s[TRIG_STAGES][a] ? -x_s[TRIG_STAGES][a] : x_s[TRIG_STAGES][a];
				xr = xc + XY_W'(512);
				yr = y_s[TRIG_STAGES][a] + XY_W'(512);
				trig[a].c <= xr[XY_W-1:10];
				trig[a].s <= yr[XY_W-1:10];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TRIG_STAGES + 2; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < TRIG_STAGES + 2; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	assign out_valid = vld_s[TRIG_STAGES+1];

	// t_s of the last stage is the residual angle; nothing reads it but this unused reduction
	logic unused_resid;
	assign unused_resid = ^t_s[TRIG_STAGES][0] ^ ^t_s[TRIG_STAGES][1] ^ ^t_s[TRIG_STAGES][2];

endmodule

[rtl/core/e2q_combine.sv]
// ----------------------------------------------------------------------------
// e2q_combine
// Pair products, triple products and the four rounded, saturated sums that
// form the quaternion. Three register stages.
// ----------------------------------------------------------------------------
module e2q_combine (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  e2q_pkg::trig_t trig [e2q_pkg::NUM_AXES],
	output logic           out_valid,
	output e2q_pkg::quat_t quat [4]
);
	import e2q_pkg::*;

	// pairs: cy*cp, sy*sp, sy*cp, cy*sp
	logic signed [PROD_W-1:0] pair_s1 [4];
	q20_t                     cr_s1, sr_s1;
	// triples: w+, w+, x+, x-, y+, y+, z+, z-
	logic signed [PROD_W-1:0] tri_s2 [8];
	logic                     vld_s1, vld_s2, vld_s3;

	function automatic q20_t rnd20(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] r;
		r = p + PROD_W'(1 << 19);
		return r[TRIG_W+19:20];
	endfunction

	function automatic quat_t finish(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W-1:0] r;
		logic signed [SUM_W-27:0] q;
		r = s + SUM_W'(1 << 25);
		q = r[SUM_W-1:26];
		if (q > SUM_W'(OUT_LIMIT) >>> 0 && q > $signed((SUM_W-26)'(OUT_LIMIT)))
			return OUT_LIMIT;
		else if (q < -$signed((SUM_W-26)'(OUT_LIMIT)))
			return -OUT_LIMIT;
		else
			return q[QUAT_W-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			pair_s1[0] <= trig[0].c * trig[1].c;
			pair_s1[1] <= trig[0].s * trig[1].s;
			pair_s1[2] <= trig[0].s * trig[1].c;
			pair_s1[3] <= trig[0].c * trig[1].s;
			cr_s1      <= trig[2].c;
			sr_s1      <= trig[2].s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tri_s2[0] <= rnd20(pair_s1[0]) * cr_s1;
			tri_s2[1] <= rnd20(pair_s1[1]) * sr_s1;
			tri_s2[2] <= rnd20(pair_s1[0]) * sr_s1;
			tri_s2[3] <= rnd20(pair_s1[1]) * cr_s1;
			tri_s2[4] <= rnd20(pair_s1[2]) * sr_s1;
			tri_s2[5] <= rnd20(pair_s1[3]) * cr_s1;
			tri_s2[6] <= rnd20(pair_s1[2]) * cr_s1;
			tri_s2[7] <= rnd20(pair_s1[3]) * sr_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quat[0] <= finish(SUM_W'(tri_s2[0]) + SUM_W'(tri_s2[1]));
			quat[1] <= finish(SUM_W'(tri_s2[2]) - SUM_W'(tri_s2[3]));
			quat[2] <= finish(SUM_W'(tri_s2[4]) + SUM_W'(tri_s2[5]));
			quat[3] <= finish(SUM_W'(tri_s2[6]) - SUM_W'(tri_s2[7]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign out_valid = vld_s3;

endmodule

[rtl/core/euler_to_quaternion.sv]
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Z-Y-X Euler angles (Q3.15 radians) to unit quaternion (Q2.14).
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction accepted per cycle unless the pipe is held.
// Stages in order: fold stage, one CORDIC step per stage, rounding, pair
// product, triple product, sum and saturate. The whole pipe advances together;
// it holds while a result waits on m_tready.
module euler_to_quaternion (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // yaw_angle, pitch_angle, roll_angle, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // quat_w, quat_x, quat_y, quat_z
);
	import e2q_pkg::*;

	logic   en;
	logic   trig_vld;
	angle_t angle [NUM_AXES];
	trig_t  trig  [NUM_AXES];
	quat_t  quat  [4];

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	assign angle[0] = s_tdata[17:0];
	assign angle[1] = s_tdata[35:18];
	assign angle[2] = s_tdata[53:36];

	e2q_trig u_trig (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.angle     (angle),
		.out_valid (trig_vld),
		.trig      (trig)
	);

	e2q_combine u_combine (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (trig_vld),
		.trig      (trig),
		.out_valid (m_tvalid),
		.quat      (quat)
	);

	assign m_tdata = {quat[3], quat[2], quat[1], quat[0]};

`ifndef NO_ASSERTIONS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
	a_w_mag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[15:0]) <= 16384 && $signed(m_tdata[15:0]) >= -16384)
		else $error("quat_w out of range");
	a_x_mag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[31:16]) <= 16384 && $signed(m_tdata[31:16]) >= -16384)
		else $error("quat_x out of range");
`endif

endmodule
